@@ src/hex_dump_row_formatter_defines.svh @@
// assertion helpers used by the checker
`ifndef HEX_DUMP_ROW_FORMATTER_DEFINES_SVH
`define HEX_DUMP_ROW_FORMATTER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HDRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HDRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/hdrf_pkg.sv @@
package hdrf_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_COLON,
      ST_HEX,
      ST_GAP,
      ST_ASCII,
      ST_EOL
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   localparam int FIFO_DEPTH = 2;

   localparam logic REQ_FLUSH = 1'b1;

   localparam logic [6:0] CH_SPACE   = 7'h20;
   localparam logic [6:0] CH_COLON   = 7'h3A;
   localparam logic [6:0] CH_DOT     = 7'h2E;
   localparam logic [6:0] CH_TILDE   = 7'h7E;
   localparam logic [6:0] CH_NEWLINE = 7'h0A;

   localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      return HEX_DIGITS[8 * (4'd15 - nib) +: 7];
   endfunction

   function automatic logic [6:0] ascii_char(input logic [7:0] d);
      logic [6:0] v;
      v = d[6:0];
      if (v < CH_SPACE || v > CH_TILDE) begin
         return CH_DOT;
      end
      return v;
   endfunction

endpackage

@@ src/hdrf_front.sv @@
module hdrf_front #(
   parameter int COLUMNS    = 8,
   parameter int ADDR_BYTES = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [31:0]                            req_addr,
   input  logic [7:0]                             req_data,
   input  hdrf_pkg::fifo_status_type              q_status,
   output logic                                   push,
   output logic [8*ADDR_BYTES+9*COLUMNS-1:0]      push_entry
);
   import hdrf_pkg::*;

   localparam int COL_W = $clog2(COLUMNS);
   localparam logic [31:0] OFS_MASK = 32'(COLUMNS - 1);

   logic               row_valid_ff, row_valid_in;
   logic [31:0]        row_base_ff, row_base_in;
   logic [COLUMNS-1:0] col_valid_ff, col_valid_in;
   logic [7:0]         col_data_ff [COLUMNS];
   logic [8*COLUMNS-1:0] data_flat;

   logic              accept;
   logic              is_flush;
   logic              other_row;
   logic [31:0]       addr_base;
   logic [COL_W-1:0]  ofs;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign is_flush  = (req_type == REQ_FLUSH);
   assign addr_base = req_addr & ~OFS_MASK;
   assign ofs       = COL_W'(req_addr & OFS_MASK);
   assign other_row = row_valid_ff && (row_base_ff != addr_base);

   // the pending row leaves on a flush or when a byte lands outside it
   assign push = accept && row_valid_ff && (is_flush || other_row);

   for (genvar i = 0; i < COLUMNS; i++) begin : g_flat
      assign data_flat[8*i +: 8] = col_data_ff[i];
   end

   assign push_entry = {row_base_ff[8*ADDR_BYTES-1:0], col_valid_ff, data_flat};

   always_comb begin
      row_valid_in = row_valid_ff;
      row_base_in  = row_base_ff;
      col_valid_in = col_valid_ff;
      if (accept) begin
         if (is_flush) begin
            row_valid_in = 1'b0;
         end else begin
            if (!row_valid_ff || other_row) begin
               row_base_in  = addr_base;
               col_valid_in = '0;
            end
            row_valid_in      = 1'b1;
            col_valid_in[ofs] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         row_base_ff  <= '0;
         col_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
         row_base_ff  <= row_base_in;
         col_valid_ff <= col_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_flush) begin
         col_data_ff[ofs] <= req_data;
      end
   end

endmodule

@@ src/hdrf_row_fifo.sv @@
module hdrf_row_fifo #(
   parameter int WIDTH = 104
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output hdrf_pkg::fifo_status_type status
);
   import hdrf_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/hdrf_back.sv @@
module hdrf_back #(
   parameter int COLUMNS    = 8,
   parameter int ADDR_BYTES = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [8*ADDR_BYTES+9*COLUMNS-1:0] entry,
   input  hdrf_pkg::fifo_status_type         q_status,
   output logic                              pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [6:0]                        out_char,
   output logic                              out_eol
);
   import hdrf_pkg::*;

   localparam int NIB_CNT = 2 * ADDR_BYTES;
   localparam int IDX_W   = $clog2(NIB_CNT);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_LEN = 2 * ADDR_BYTES + 3 + 4 * COLUMNS;
   localparam int PEND_W  = $clog2(ROW_LEN + 1);

   back_state_type state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [1:0]        phase_ff, phase_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              out_valid_ff;
   logic [6:0]        out_char_ff;
   logic              out_eol_ff;

   logic [8*ADDR_BYTES-1:0] ent_base;
   logic [COLUMNS-1:0]      ent_mask;
   logic [8*COLUMNS-1:0]    ent_bytes;
   logic [7:0]              cur_byte;
   logic [IDX_W-1:0]        dsel;
   logic [3:0]              nib;

   logic       emit_ok;
   logic [6:0] cur_char;
   logic       cur_space;
   logic       advance;
   logic       load;
   logic [6:0] load_char;
   logic       load_eol;

   assign ent_bytes = entry[8*COLUMNS-1:0];
   assign ent_mask  = entry[8*COLUMNS +: COLUMNS];
   assign ent_base  = entry[9*COLUMNS +: 8*ADDR_BYTES];
   assign cur_byte  = ent_bytes[8*col_ff +: 8];
   assign dsel      = IDX_W'(NIB_CNT - 1) - idx_ff;
   assign nib       = ent_base[4*dsel +: 4];

   assign emit_ok   = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_eol   = out_eol_ff;

   // character at the current row position
   always_comb begin
      cur_char = CH_SPACE;
      case (state_ff)
         ST_ADDR: begin
            cur_char = hex_char(nib);
         end
         ST_COLON: begin
            cur_char = (idx_ff == '0) ? CH_COLON : CH_SPACE;
         end
         ST_HEX: begin
            if (ent_mask[col_ff]) begin
               if (phase_ff == 2'd0) begin
                  cur_char = hex_char(cur_byte[7:4]);
               end else if (phase_ff == 2'd1) begin
                  cur_char = hex_char(cur_byte[3:0]);
               end
            end
         end
         ST_ASCII: begin
            if (ent_mask[col_ff]) begin
               cur_char = ascii_char(cur_byte);
            end
         end
         default: begin
            cur_char = CH_SPACE;
         end
      endcase
   end

   assign cur_space = (cur_char == CH_SPACE);
   // spaces are only counted; they go out once a later visible character shows up
   assign advance   = cur_space || (pend_ff == '0 && emit_ok);

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               state_in = ST_ADDR;
               idx_in   = '0;
            end
         end
         ST_ADDR: begin
            if (advance) begin
               if (idx_ff == IDX_W'(NIB_CNT - 1)) begin
                  state_in = ST_COLON;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_COLON: begin
            if (advance) begin
               if (idx_ff == IDX_W'(1)) begin
                  state_in = ST_HEX;
                  col_in   = '0;
                  phase_in = 2'd0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_HEX: begin
            if (advance) begin
               if (phase_ff == 2'd2) begin
                  phase_in = 2'd0;
                  if (col_ff == COL_W'(COLUMNS - 1)) begin
                     state_in = ST_GAP;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         ST_GAP: begin
            if (advance) begin
               state_in = ST_ASCII;
               col_in   = '0;
            end
         end
         ST_ASCII: begin
            if (advance) begin
               if (col_ff == COL_W'(COLUMNS - 1)) begin
                  state_in = ST_EOL;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_EOL: begin
            if (emit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      pend_in   = pend_ff;
      load      = 1'b0;
      load_char = CH_SPACE;
      load_eol  = 1'b0;
      pop       = 1'b0;
      case (state_ff)
         ST_ADDR, ST_COLON, ST_HEX, ST_GAP, ST_ASCII: begin
            if (cur_space) begin
               pend_in = pend_ff + 1'b1;
            end else if (emit_ok) begin
               load = 1'b1;
               if (pend_ff != '0) begin
                  load_char = CH_SPACE;
                  pend_in   = pend_ff - 1'b1;
               end else begin
                  load_char = cur_char;
               end
            end
         end
         ST_EOL: begin
            if (emit_ok) begin
               load      = 1'b1;
               load_char = CH_NEWLINE;
               load_eol  = 1'b1;
               pop       = 1'b1;
               pend_in   = '0;
            end
         end
         default: begin
            pend_in = pend_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         col_ff       <= '0;
         phase_ff     <= '0;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         col_ff   <= col_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_char_ff <= load_char;
         out_eol_ff  <= load_eol;
      end
   end

endmodule

@@ src/hex_dump_row_formatter.sv @@
// Hex dump row formatter.
// req channel: one beat per data byte (tuser = 0) or flush (tuser = 1). Bytes
// gather into a row of COLUMNS aligned addresses. A byte outside the pending
// row, or a flush, closes that row and hands it to the character sequencer.
// rsp channel: one beat per character of a closed row, trailing spaces trimmed,
// then a newline beat with tlast high.
// After the beat that closes a row is accepted, the row is written to the row
// queue, the idle sequencer picks it up and the first character is registered.
// Throughput: the front takes one beat per cycle while its two-entry row queue
// has room. The sequencer steps through every row position and also spends a
// step on each inner space that it sends, then sends the newline and returns
// to idle. The back-end sequencer sets the sustained rate.
// Reset (synchronous) drops the pending row, empties the queue and clears the
// output valid flag. A stalled rsp holds its beat; the sequencer waits, the queue
// fills, and req_tready falls once both queue entries hold closed rows.
module hex_dump_row_formatter #(
   parameter int COLUMNS    = 8,
   parameter int ADDR_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // byte_address[31:0], data_byte[39:32]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // text_char[6:0], zero[7]
   output logic        rsp_tlast
);
   import hdrf_pkg::*;

   localparam int ENTRY_W = 8 * ADDR_BYTES + 9 * COLUMNS;

   fifo_status_type    q_status;
   logic               push, pop;
   logic [ENTRY_W-1:0] push_entry, pop_entry;
   logic [6:0]         text_char;

   hdrf_front #(
      .COLUMNS    (COLUMNS),
      .ADDR_BYTES (ADDR_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_type   (req_tuser),
      .req_addr   (req_tdata[31:0]),
      .req_data   (req_tdata[39:32]),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   hdrf_row_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .status    (q_status)
   );

   hdrf_back #(
      .COLUMNS    (COLUMNS),
      .ADDR_BYTES (ADDR_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .entry     (pop_entry),
      .q_status  (q_status),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (text_char),
      .out_eol   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, text_char};

endmodule

@@ src/hdrf_checker.sv @@
`include "hex_dump_row_formatter_defines.svh"

module hdrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);
   import hdrf_pkg::*;

   // a held beat keeps its character and line mark
   `HDRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp beat changed while stalled")

   // tlast marks exactly the newline
   `HDRF_ASSERT_NOW(a_eol_newline, clock, reset, rsp_tvalid,
      rsp_tlast == (rsp_tdata[6:0] == CH_NEWLINE), "line end and newline disagree")

   // row characters are at or above space and the pad bit stays low
   `HDRF_ASSERT_NOW(a_printable, clock, reset, rsp_tvalid && !rsp_tlast,
      rsp_tdata[6:0] >= CH_SPACE && rsp_tdata[7] == 1'b0, "non-printable row character")

   // nothing is offered right after reset
   `HDRF_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset,
      !rsp_tvalid, "rsp valid after reset")

endmodule

bind hex_dump_row_formatter hdrf_checker u_checker (.*);

@@ tb/tb_hex_dump_row_formatter.sv @@
module tb_hex_dump_row_formatter;
   import hdrf_pkg::*;

   localparam int COLUMNS     = 8;
   localparam int ADDR_BYTES  = 4;
   localparam int ADDR_DIGITS = 2 * ADDR_BYTES;
   localparam int ROW_LEN     = ADDR_DIGITS + 3 + 4 * COLUMNS;
   localparam logic [31:0] OFS_MASK = 32'(COLUMNS - 1);
   localparam logic REQ_DATA = ~REQ_FLUSH;
   localparam int IDLE_PCT = 31;

   typedef struct packed {
      logic [6:0] ch;
      logic       eol;
   } text_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // byte_address[31:0], data_byte[39:32]
   logic        req_tuser = 1'b0; // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // text_char[6:0], zero[7]
   logic        rsp_tlast;

   // predicted row state
   logic [6:0]    row_img [ROW_LEN];
   logic [31:0]   row_base;
   logic          row_open;
   text_beat_type row_chars_due[$];

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int fail_count = 0;

   always #4 clock = ~clock;

   hex_dump_row_formatter #(
      .COLUMNS(COLUMNS),
      .ADDR_BYTES(ADDR_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always @(posedge clock) begin
      rsp_tready <= !(rsp_idle_on && $urandom_range(99) < IDLE_PCT);
   end

   // 0x37 + 10 is 'A'
   function automatic logic [6:0] nibble_glyph(input logic [3:0] n);
      return (n < 4'd10) ? 7'h30 + 7'(n) : 7'h37 + 7'(n);
   endfunction

   function automatic void write_hex_pair(input int pos, input logic [7:0] v);
      row_img[pos]     = nibble_glyph(v[7:4]);
      row_img[pos + 1] = nibble_glyph(v[3:0]);
   endfunction

   function automatic void clear_row();
      foreach (row_img[i]) row_img[i] = CH_SPACE;
      row_open = 1'b0;
   endfunction

   function automatic void close_row();
      int last;
      if (!row_open) return;
      last = ROW_LEN;
      while (last > 0 && row_img[last - 1] == CH_SPACE) last--;
      for (int i = 0; i < last; i++) row_chars_due.push_back('{row_img[i], 1'b0});
      row_chars_due.push_back('{CH_NEWLINE, 1'b1});
      clear_row();
   endfunction

   function automatic void apply_item(input logic kind, input logic [31:0] addr,
                                      input logic [7:0] data);
      logic [31:0] row_addr;
      int          ofs;
      logic [6:0]  shown;
      if (kind == REQ_FLUSH) begin
         close_row();
         return;
      end
      row_addr = addr & ~OFS_MASK;
      // membership uses the whole 32-bit base, not just the printed digits
      if (row_open && row_base != row_addr) close_row();
      if (!row_open) begin
         row_base = row_addr;
         for (int i = 0; i < ADDR_BYTES; i++)
            write_hex_pair(2 * (ADDR_BYTES - 1 - i), row_addr[8 * i +: 8]);
         row_img[ADDR_DIGITS] = CH_COLON;
         row_open = 1'b1;
      end
      ofs = int'(addr & OFS_MASK);
      write_hex_pair(ADDR_DIGITS + 2 + 3 * ofs, data);
      shown = data[6:0];
      if (shown < CH_SPACE || shown > CH_TILDE) shown = CH_DOT;
      row_img[ADDR_DIGITS + 3 + 3 * COLUMNS + ofs] = shown;
   endfunction

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic send_item(input logic kind, input logic [31:0] addr, input logic [7:0] data);
      if (req_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PCT) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {data, addr};
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      apply_item(kind, addr, data);
      @(posedge clock);
   endtask

   task automatic send_flush();
      send_item(REQ_FLUSH, $urandom, 8'($urandom_range(255)));
   endtask

   task automatic release_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   always @(negedge clock) begin : beat_check
      text_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (row_chars_due.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual tdata=%h tlast=%b",
                     $time, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = row_chars_due.pop_front();
            if (rsp_tdata !== {1'b0, want.ch}) begin
               $display("%0t: text_char mismatch, expected %h actual %h",
                        $time, {1'b0, want.ch}, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.eol) begin
               $display("%0t: end_of_line mismatch, expected %b actual %b",
                        $time, want.eol, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   task automatic test_empty_flush();
      send_flush();
      send_flush();
      release_req();
   endtask

   // one full row, data covering the edges of the printable range
   task automatic test_full_row();
      logic [7:0] vals [COLUMNS];
      vals = '{8'h00, 8'h1F, 8'h20, 8'h41, 8'h7E, 8'h7F, 8'h80, 8'hFF};
      for (int i = 0; i < COLUMNS; i++) send_item(REQ_DATA, 32'h1234_5670 + i, vals[i]);
      send_flush();
      release_req();
   endtask

   task automatic test_overwrite_and_trim();
      send_item(REQ_DATA, 32'hFFFF_FFFF, 8'hFE);
      // masks to a space in the last ascii cell, so the row trims down to hex
      send_item(REQ_DATA, 32'hFFFF_FFFF, 8'hA0);
      send_item(REQ_DATA, 32'h0000_0000, 8'h5A);
      send_item(REQ_DATA, 32'h8000_0000, 8'hC1);
      send_item(REQ_DATA, 32'h8000_0003, 8'h9F);
      send_flush();
      release_req();
   endtask

   task automatic test_row_switch();
      send_item(REQ_DATA, 32'h0000_0007, 8'h33);
      send_item(REQ_DATA, 32'h0000_0008, 8'h44);
      send_item(REQ_DATA, 32'hFFFF_FFF8, 8'h00);
      send_flush();
      release_req();
   endtask

   task automatic random_traffic(input int n_items);
      int          sent;
      int          pick;
      int          run_len;
      int          start;
      logic [31:0] base;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         case ($urandom_range(9))
            0: base = 32'h0;
            1: base = ~OFS_MASK;
            default: base = $urandom & ~OFS_MASK;
         endcase
         if (pick < 60) begin
            // consecutive bytes, may spill into the following rows
            start = $urandom_range(COLUMNS - 1);
            run_len = $urandom_range(1, 2 * COLUMNS);
            for (int k = 0; k < run_len; k++)
               send_item(REQ_DATA, base + start + k, 8'($urandom_range(255)));
            sent += run_len;
         end else if (pick < 85) begin
            run_len = $urandom_range(1, COLUMNS + 2);
            for (int k = 0; k < run_len; k++)
               send_item(REQ_DATA, base + $urandom_range(COLUMNS - 1),
                         8'($urandom_range(255)));
            sent += run_len;
         end else begin
            if ($urandom_range(1)) send_flush();
            else send_item(REQ_DATA, $urandom, 8'($urandom_range(255)));
            sent++;
         end
         if ($urandom_range(99) < 35) begin
            send_flush();
            sent++;
         end
      end
   endtask

   task automatic test_streaming_no_idle();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      random_traffic(80);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      release_req();
   endtask

   task automatic test_random_traffic();
      random_traffic(240);
      send_flush();
      release_req();
   endtask

   initial begin
      clear_row();
      row_base = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_flush();
      test_full_row();
      test_overwrite_and_trim();
      test_row_switch();
      test_streaming_no_idle();
      test_random_traffic();
      while (row_chars_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/hdrf_pkg.sv
src/hdrf_front.sv
src/hdrf_row_fifo.sv
src/hdrf_back.sv
src/hex_dump_row_formatter.sv
src/hdrf_checker.sv
tb/tb_hex_dump_row_formatter.sv
